// File: rtl/assert_macros.svh
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/htb_pkg.sv
// Types, constants and helpers of the hex text to bytes parser.
package htb_pkg;

   localparam int unsigned CHAR_W  = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_CHARS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTES_ENABLED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT      = 2'd2;

   // Reset values of the registers
   localparam logic                RST_WIDE_CHARS     = 1'b0;
   localparam logic                RST_QUOTES_ENABLED = 1'b1;
   localparam logic [COUNT_W-1:0]  RST_OUT_LIMIT      = 16'hFFFF;

   // Character codes
   localparam logic [CHAR_W-1:0] CHAR_NUL   = 16'h0000;
   localparam logic [CHAR_W-1:0] CHAR_DQ    = 16'h0022;
   localparam logic [CHAR_W-1:0] CHAR_SQ    = 16'h0027;
   localparam logic [CHAR_W-1:0] CHAR_0     = 16'h0030;
   localparam logic [CHAR_W-1:0] CHAR_9     = 16'h0039;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 16'h0041;
   localparam logic [CHAR_W-1:0] CHAR_UC_F  = 16'h0046;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 16'h0061;
   localparam logic [CHAR_W-1:0] CHAR_LC_F  = 16'h0066;
   localparam logic [3:0]        DIGIT_TEN  = 4'd10;

   typedef enum logic [2:0] {
      MODE_HEX = 3'b001,
      MODE_SQ  = 3'b010,
      MODE_DQ  = 3'b100
   } mode_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic              first_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic [COUNT_W-1:0] byte_count;
      logic               done_res;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   // Decode one hex digit of either case
   function automatic digit_type hex_digit(input logic [CHAR_W-1:0] ch);
      digit_type d;
      d.valid = 1'b0;
      d.value = 4'd0;
      if (ch >= CHAR_0 && ch <= CHAR_9) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_0);
      end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_UC_A) + DIGIT_TEN;
      end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
         d.valid = 1'b1;
         d.value = 4'(ch - CHAR_LC_A) + DIGIT_TEN;
      end
      return d;
   endfunction

endpackage

// File: rtl/hex_text_to_bytes_parser.sv
// Hex text to bytes parser: one character in, one or two result items out.
// Each accepted character's result items are written into a registered result queue.
// Throughput: one character per cycle while req_ready is high; a wide literal character
// yields two items, so req_ready drops after each wide literal character is taken.
// A three-slot result queue absorbs the second item; req_ready drops while it holds two or more.
// Reset (synchronous): parser state and queue cleared, wide_chars 0, quotes on, limit 65535.
`include "assert_macros.svh"
module hex_text_to_bytes_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  htb_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output htb_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [htb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [htb_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import htb_pkg::*;

   localparam int unsigned QDEPTH = 3;

   // Configuration registers
   logic               wide_ff;
   logic               quotes_ff;
   logic [COUNT_W-1:0] limit_ff;

   // Parser state
   mode_type           mode_ff, mode_in;
   logic               pend_ff, pend_in;
   logic [3:0]         hi_ff, hi_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               stop_ff, stop_in;

   // Result queue, slot 0 is the head
   rsp_type            q_ff [QDEPTH];
   rsp_type            q_in [QDEPTH];
   logic [1:0]         q_cnt_ff, q_cnt_in;

   // Step logic
   logic               req_fire;
   logic               rsp_fire;
   logic               two_res;
   rsp_type            res0, res1;
   mode_type           mode_c, mode_eff;
   logic               pend_c;
   logic [3:0]         hi_c;
   logic [COUNT_W-1:0] cnt_c;
   logic               stop_c;
   logic [CHAR_W-1:0]  ch;
   logic [CHAR_W-1:0]  quote_ch;
   logic [COUNT_W:0]   cnt_p1, cnt_p2, lim_x;
   digit_type          dig;
   logic [1:0]         base;

   assign req_ready = (q_cnt_ff <= 2'd1);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (q_cnt_ff != 2'd0);
   assign rsp_data  = q_ff[0];
   assign rsp_fire  = rsp_valid && rsp_ready;

   // Work out the results and next state of one character
   always_comb begin
      mode_c = req_data.first_of_string ? MODE_HEX : mode_ff;
      pend_c = req_data.first_of_string ? 1'b0 : pend_ff;
      hi_c   = req_data.first_of_string ? 4'd0 : hi_ff;
      cnt_c  = req_data.first_of_string ? '0 : cnt_ff;
      stop_c = req_data.first_of_string ? 1'b0 : stop_ff;

      ch = wide_ff ? req_data.char_code : {8'h00, req_data.char_code[7:0]};

      if (!quotes_ff) begin
         mode_eff = MODE_HEX;
      end else begin
         unique case (mode_c)
            MODE_SQ: mode_eff = MODE_SQ;
            MODE_DQ: mode_eff = MODE_DQ;
            default: mode_eff = MODE_HEX;
         endcase
      end
      quote_ch = (mode_eff == MODE_DQ) ? CHAR_DQ : CHAR_SQ;

      cnt_p1 = {1'b0, cnt_c} + (COUNT_W+1)'(1);
      cnt_p2 = {1'b0, cnt_c} + (COUNT_W+1)'(2);
      lim_x  = {1'b0, limit_ff};
      dig    = hex_digit(ch);

      mode_in = mode_c;
      pend_in = pend_c;
      hi_in   = hi_c;
      cnt_in  = cnt_c;
      stop_in = stop_c;
      two_res = 1'b0;

      res0.out_byte    = 8'h00;
      res0.byte_valid  = 1'b0;
      res0.byte_count  = cnt_c;
      res0.done_res    = 1'b0;
      res0.last_of_run = 1'b1;
      res1             = res0;

      priority if (stop_c) begin
         res0.done_res = 1'b1;
      end else if (cnt_c >= limit_ff || ch == CHAR_NUL) begin
         // Stop on the byte limit or on the string terminator
         stop_in       = 1'b1;
         res0.done_res = 1'b1;
      end else if (mode_eff != MODE_HEX) begin
         // Inside a literal run
         mode_in = mode_eff;
         if (ch == quote_ch) begin
            mode_in = MODE_HEX;
         end else if (!wide_ff) begin
            cnt_in          = cnt_p1[COUNT_W-1:0];
            stop_in         = (cnt_p1 >= lim_x);
            res0.out_byte   = ch[7:0];
            res0.byte_valid = 1'b1;
            res0.byte_count = cnt_p1[COUNT_W-1:0];
            res0.done_res   = (cnt_p1 >= lim_x);
         end else if (cnt_p1 < lim_x) begin
            two_res          = 1'b1;
            cnt_in           = cnt_p2[COUNT_W-1:0];
            stop_in          = (cnt_p2 >= lim_x);
            res0.out_byte    = ch[7:0];
            res0.byte_valid  = 1'b1;
            res0.byte_count  = cnt_p1[COUNT_W-1:0];
            res0.last_of_run = 1'b0;
            res1.out_byte    = ch[15:8];
            res1.byte_valid  = 1'b1;
            res1.byte_count  = cnt_p2[COUNT_W-1:0];
            res1.done_res    = (cnt_p2 >= lim_x);
            res1.last_of_run = 1'b1;
         end else begin
            stop_in       = 1'b1;
            res0.done_res = 1'b1;
         end
      end else begin
         // Hex text
         mode_in = MODE_HEX;
         if (quotes_ff && (ch == CHAR_DQ || ch == CHAR_SQ)) begin
            mode_in = (ch == CHAR_DQ) ? MODE_DQ : MODE_SQ;
            pend_in = 1'b0;
         end else if (dig.valid && !pend_c) begin
            hi_in   = dig.value;
            pend_in = 1'b1;
         end else if (dig.valid) begin
            pend_in         = 1'b0;
            cnt_in          = cnt_p1[COUNT_W-1:0];
            stop_in         = (cnt_p1 >= lim_x);
            res0.out_byte   = {hi_c, dig.value};
            res0.byte_valid = 1'b1;
            res0.byte_count = cnt_p1[COUNT_W-1:0];
            res0.done_res   = (cnt_p1 >= lim_x);
         end
      end
   end

   // Shift the queue on a pop and append new result items behind the survivors
   always_comb begin
      base = q_cnt_ff - {1'b0, rsp_fire};
      for (int i = 0; i < QDEPTH; i++) begin
         if (rsp_fire && i < QDEPTH-1) begin
            q_in[i] = q_ff[i+1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if (req_fire && base == 2'(i)) begin
            q_in[i] = res0;
         end
         if (req_fire && two_res && base + 2'd1 == 2'(i)) begin
            q_in[i] = res1;
         end
      end
      q_cnt_in = base + (req_fire ? (two_res ? 2'd2 : 2'd1) : 2'd0);
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff   <= RST_WIDE_CHARS;
         quotes_ff <= RST_QUOTES_ENABLED;
         limit_ff  <= RST_OUT_LIMIT;
      end else if (csr_we) begin
         if (csr_index == CSR_WIDE_CHARS) begin
            wide_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_QUOTES_ENABLED) begin
            quotes_ff <= csr_wdata[0];
         end
         if (csr_index == CSR_OUT_LIMIT) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Advance parser state on each accepted item and track the queue count
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HEX;
         pend_ff  <= 1'b0;
         hi_ff    <= 4'd0;
         cnt_ff   <= '0;
         stop_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (req_fire) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            hi_ff   <= hi_in;
            cnt_ff  <= cnt_in;
            stop_ff <= stop_in;
         end
         q_cnt_ff <= q_cnt_in;
      end
   end

   // Hold queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `ASSERT_CLK(a_two_fit, clock, reset,
      (req_fire && two_res) |-> (q_cnt_ff <= 2'd1))
   `ASSERT_CLK(a_stopped_blank, clock, reset,
      (req_fire && stop_ff && !req_data.first_of_string) |->
         (res0.done_res && !res0.byte_valid && !two_res))
   `ASSERT_CLK(a_within_limit, clock, reset,
      (req_fire && res0.byte_valid) |-> (res0.byte_count <= limit_ff))
   `ASSERT_CLK(a_pair_order, clock, reset,
      (req_fire && two_res) |-> (!res0.last_of_run && res1.last_of_run))
   `ASSERT_NEVER(a_queue_over, clock, reset, q_cnt_ff == 2'd3 && !rsp_fire && req_fire)

endmodule

// File: tb/tb.sv
// Testbench of the hex text to bytes parser: directed and random text checked against a shadow.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import htb_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 145;

   // Shadow of the parser: predicts the result items each character yields
   class byte_predictor;
      bit                 wide_chars;
      bit                 quotes_on;
      logic [COUNT_W-1:0] out_limit;
      mode_type           mode;
      bit                 nibble_pending;
      logic [3:0]         high_nibble;
      logic [COUNT_W-1:0] produced;
      bit                 stopped;
      rsp_type            expected_bytes[$];
      int                 errors;

      function new();
         wide_chars = RST_WIDE_CHARS;
         quotes_on  = RST_QUOTES_ENABLED;
         out_limit  = RST_OUT_LIMIT;
         errors     = 0;
         clear_string();
      endfunction

      // Value of a hex digit in the low nibble; bit 4 set when not a digit
      static function logic [4:0] digit_of(logic [CHAR_W-1:0] ch);
         if (ch >= CHAR_0 && ch <= CHAR_9) return {1'b0, 4'(ch - CHAR_0)};
         if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) return {1'b0, 4'(ch - CHAR_UC_A + 16'd10)};
         if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) return {1'b0, 4'(ch - CHAR_LC_A + 16'd10)};
         return 5'h10;
      endfunction

      function void clear_string();
         mode           = MODE_HEX;
         nibble_pending = 1'b0;
         high_nibble    = 4'h0;
         produced       = '0;
         stopped        = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_WIDE_CHARS:     wide_chars = val[0];
            CSR_QUOTES_ENABLED: quotes_on  = val[0];
            CSR_OUT_LIMIT:      out_limit  = val;
            default: ;
         endcase
      endfunction

      function void queue_byte(logic [7:0] b, bit valid, bit done, bit last);
         rsp_type r;
         r.out_byte    = valid ? b : 8'h00;
         r.byte_valid  = valid;
         r.byte_count  = produced;
         r.done_res    = done;
         r.last_of_run = last;
         expected_bytes.push_back(r);
      endfunction

      // Count one produced byte and stop at the limit
      function void bump();
         produced++;
         stopped = (produced >= out_limit);
      endfunction

      function void take_char(req_type r);
         logic [CHAR_W-1:0] ch;
         logic [CHAR_W-1:0] close_q;
         logic [4:0]        digit;
         if (r.first_of_string) clear_string();
         if (stopped) begin
            queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
            return;
         end
         if (produced >= out_limit) begin
            stopped = 1'b1;
            queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
            return;
         end
         ch = wide_chars ? r.char_code : {8'h00, r.char_code[7:0]};
         if (ch == CHAR_NUL) begin
            stopped = 1'b1;
            queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
            return;
         end
         // Drop an open literal run when quotes are off
         if (!quotes_on) mode = MODE_HEX;
         if (mode != MODE_HEX) begin
            close_q = (mode == MODE_DQ) ? CHAR_DQ : CHAR_SQ;
            if (ch == close_q) begin
               mode = MODE_HEX;
               queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
               return;
            end
            if (!wide_chars) begin
               bump();
               queue_byte(ch[7:0], 1'b1, stopped, 1'b1);
               return;
            end
            // Wide literal needs room for two bytes under the limit, low byte first
            if ({1'b0, produced} + 17'd1 < {1'b0, out_limit}) begin
               produced++;
               queue_byte(ch[7:0], 1'b1, 1'b0, 1'b0);
               bump();
               queue_byte(ch[15:8], 1'b1, stopped, 1'b1);
               return;
            end
            stopped = 1'b1;
            queue_byte(8'h00, 1'b0, 1'b1, 1'b1);
            return;
         end
         // Open a literal run and drop a half-formed byte
         if (quotes_on && (ch == CHAR_DQ || ch == CHAR_SQ)) begin
            if (ch == CHAR_DQ) mode = MODE_DQ;
            else mode = MODE_SQ;
            nibble_pending = 1'b0;
            queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
            return;
         end
         digit = digit_of(ch);
         if (digit[4]) begin
            queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
            return;
         end
         if (!nibble_pending) begin
            high_nibble    = digit[3:0];
            nibble_pending = 1'b1;
            queue_byte(8'h00, 1'b0, 1'b0, 1'b1);
            return;
         end
         nibble_pending = 1'b0;
         bump();
         queue_byte({high_nibble, digit[3:0]}, 1'b1, stopped, 1'b1);
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("result item with nothing pending: %p", got);
            errors++;
            return;
         end
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            errors++;
         end
         if (got.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, got.byte_valid);
            errors++;
         end
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
            errors++;
         end
         if (got.done_res !== want.done_res) begin
            $error("done_res: expected %0b, got %0b", want.done_res, got.done_res);
            errors++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   byte_predictor shadow;
   bit            wide_now    = RST_WIDE_CHARS;
   bit            start_next  = 1'b0;
   bit            req_up      = 1'b0;
   bit            calm        = 1'b0;
   int            burst_left  = 0;
   int            restart_pct = 7;
   int            sent_in_phase;
   int            idle_cycles = 0;
   int            stall_left  = 0;
   int unsigned   cycle_no    = 0;

   hex_text_to_bytes_parser uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Stall the result side in short random bursts, with calm windows
   always @(posedge clock) begin
      cycle_no++;
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!cycle_no[9] && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted result item
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) shadow.check_byte(rsp_data);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic lower_req();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   // Offer one character, hold it until accepted, then pace the bursts
   task automatic send_char(input logic [CHAR_W-1:0] ch);
      req_type r;
      int      gap;
      r.char_code       = ch;
      r.first_of_string = start_next;
      start_next        = 1'b0;
      req_valid <= 1'b1;
      req_data  <= r;
      req_up = 1'b1;
      do @(posedge clock); while (!req_ready);
      shadow.take_char(r);
      sent_in_phase++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            lower_req();
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Write a register once the parser has drained
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      lower_req();
      while (shadow.expected_bytes.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.write_reg(idx, val);
      if (idx == CSR_WIDE_CHARS) wide_now = val[0];
   endtask

   task automatic set_config(input bit wide, input bit quotes, input logic [COUNT_W-1:0] lim);
      write_reg(CSR_WIDE_CHARS, CSR_DATA_W'(wide));
      write_reg(CSR_QUOTES_ENABLED, CSR_DATA_W'(quotes));
      write_reg(CSR_OUT_LIMIT, lim);
      restart_pct = (lim < 64) ? 25 : 7;
   endtask

   // Put random junk in the ignored high byte in narrow mode
   function automatic logic [CHAR_W-1:0] dress(logic [CHAR_W-1:0] ch);
      return wide_now ? ch : {8'($urandom), ch[7:0]};
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(logic [3:0] v);
      if (v < 4'd10) return CHAR_0 + CHAR_W'(v);
      if ($urandom_range(0, 1)) return CHAR_UC_A + CHAR_W'(v - 4'd10);
      return CHAR_LC_A + CHAR_W'(v - 4'd10);
   endfunction

   // Separator from codes 1 to 126 that is neither a digit nor a quote
   function automatic logic [CHAR_W-1:0] filler_char();
      logic [CHAR_W-1:0] c;
      logic [4:0]        dv;
      do begin
         c  = CHAR_W'($urandom_range(1, 126));
         dv = byte_predictor::digit_of(c);
      end while (!dv[4] || c == CHAR_SQ || c == CHAR_DQ);
      return dress(c);
   endfunction

   // Literal content: anything but the closing quote or a string end
   function automatic logic [CHAR_W-1:0] literal_char(logic [CHAR_W-1:0] close_q);
      logic [CHAR_W-1:0] c;
      logic [CHAR_W-1:0] eff;
      do begin
         if ($urandom_range(0, 3) == 0) c = dress(CHAR_W'($urandom_range(32, 126)));
         else c = CHAR_W'($urandom);
         eff = wide_now ? c : {8'h00, c[7:0]};
      end while (eff == CHAR_NUL || eff == close_q);
      return c;
   endfunction

   // One well-formed fragment of hex text, or a little noise
   task automatic send_chunk();
      int                kind;
      logic [7:0]        v;
      logic [CHAR_W-1:0] q;
      if ($urandom_range(0, 99) < restart_pct) start_next = 1'b1;
      kind = $urandom_range(0, 99);
      q    = $urandom_range(0, 1) ? CHAR_SQ : CHAR_DQ;
      if (kind < 45) begin
         v = 8'($urandom);
         send_char(dress(digit_char(v[7:4])));
         send_char(dress(digit_char(v[3:0])));
         if ($urandom_range(0, 2) == 0) send_char(filler_char());
      end else if (kind < 68) begin
         send_char(dress(q));
         repeat ($urandom_range(0, 6)) send_char(literal_char(q));
         if ($urandom_range(0, 4) != 0) send_char(dress(q));
      end else if (kind < 76) begin
         send_char(dress(digit_char(4'($urandom))));
         if ($urandom_range(0, 1)) send_char(dress(q));
      end else if (kind < 80) begin
         send_char(dress(CHAR_NUL));
         if ($urandom_range(0, 3) != 0) start_next = 1'b1;
      end else if ($urandom_range(0, 1)) begin
         send_char(CHAR_W'($urandom));
      end else begin
         send_char(dress(CHAR_W'($urandom_range(1, 127))));
      end
   endtask

   task automatic run_phase(input int n);
      sent_in_phase = 0;
      calm = ($urandom_range(0, 3) == 0);
      while (sent_in_phase < n) send_chunk();
   endtask

   initial begin
      shadow = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Digit range edges of both cases, separators, quotes of both kinds
      start_next = 1'b1;
      send_char(CHAR_0);
      send_char(CHAR_9);
      send_char(CHAR_UC_A);
      send_char(CHAR_UC_F);
      send_char(CHAR_LC_A);
      send_char(CHAR_LC_F);
      send_char(CHAR_LC_F + 16'd1);
      send_char(CHAR_0 - 16'd1);
      send_char(CHAR_SQ);
      send_char(16'h0078);
      send_char(CHAR_DQ);
      send_char(CHAR_SQ);
      // Half byte dropped by a quote
      send_char(CHAR_0 + 16'd3);
      send_char(CHAR_DQ);
      send_char(16'h0071);
      send_char(CHAR_DQ);
      // High byte ignored in narrow mode, then a narrow zero ends the string
      send_char(16'hFF46);
      send_char(CHAR_0 + 16'd1);
      send_char(16'hFF00);
      send_char(CHAR_LC_A);
      // New string left inside a literal run
      start_next = 1'b1;
      send_char(CHAR_0 + 16'd5);
      send_char(CHAR_SQ);
      send_char(16'h006B);
      // Quotes turned off mid-run, then limit lowered to the count
      write_reg(CSR_QUOTES_ENABLED, '0);
      send_char(CHAR_0 + 16'd4);
      send_char(CHAR_0 + 16'd2);
      write_reg(CSR_OUT_LIMIT, CSR_DATA_W'(2));
      send_char(CHAR_LC_A + 16'd2);

      // Random text across settings, extremes first
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_config(1'b1, 1'b1, 16'hFFFF);
            1: set_config(1'b1, 1'b1, 16'd1);
            2: set_config(1'b0, 1'b0, 16'd2);
            3: set_config(1'b1, 1'b1, 16'd3);
            default: begin
               case ($urandom_range(0, 4))
                  0: set_config(1'($urandom), $urandom_range(0, 3) != 0, 16'd1);
                  1: set_config(1'($urandom), $urandom_range(0, 3) != 0, 16'hFFFF);
                  2: set_config(1'($urandom), $urandom_range(0, 3) != 0,
                                16'($urandom_range(2, 8)));
                  3: set_config(1'($urandom), $urandom_range(0, 3) != 0,
                                16'($urandom_range(9, 60)));
                  default: set_config(1'($urandom), $urandom_range(0, 3) != 0,
                                      16'($urandom_range(1, 65535)));
               endcase
            end
         endcase
         if ($urandom_range(0, 1)) start_next = 1'b1;
         run_phase(PHASE_ITEMS);
      end

      // Drain and let the pipeline settle
      lower_req();
      while (shadow.expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (shadow.errors == 0 && shadow.expected_bytes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
